/* rtl/tdpu_pkg.sv */
// Package for the Thumb data-processing unit: opcodes, ALU codes, shift kinds, payload structs.
// No dependencies.
`default_nettype none
package tdpu_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned RegN = 16;
	localparam int unsigned RegIdxW = 4;

	typedef enum logic [1:0] {
		OP_EXEC = 2'd0,
		OP_LDREG = 2'd1,
		OP_LDFLAG = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ALU_AND = 4'h0, ALU_EOR = 4'h1, ALU_LSL = 4'h2, ALU_LSR = 4'h3,
		ALU_ASR = 4'h4, ALU_ADC = 4'h5, ALU_SBC = 4'h6, ALU_ROR = 4'h7,
		ALU_TST = 4'h8, ALU_NEG = 4'h9, ALU_CMP = 4'hA, ALU_CMN = 4'hB,
		ALU_ORR = 4'hC, ALU_MUL = 4'hD, ALU_BIC = 4'hE, ALU_MVN = 4'hF
	} alu_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
	} shift_t;

	typedef struct packed {
		logic [1:0] op;
		logic [15:0] instruction;
		logic [3:0] reg_index;
		logic [31:0] reg_value;
	} in_beat_t;

	typedef struct packed {
		logic handled;
		logic dest_written;
		logic [3:0] dest_index;
		logic [31:0] dest_value;
		logic flag_n;
		logic flag_z;
		logic flag_c;
		logic flag_v;
		logic pc_written;
	} out_beat_t;
endpackage
`default_nettype wire

/* rtl/tdpu_if.sv */
// Valid/ready channel carrying one beat of a struct payload.
// Generic payload type; used with tdpu_pkg structs.
`default_nettype none
interface tdpu_if #(parameter type payload_t = logic) (input wire logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/thumb_data_processing_unit.sv */
// Top level of the Thumb data-processing unit.
// Depends on tdpu_pkg, tdpu_if, tdpu_ram, tdpu_shift.
//
// Accepts one beat per cycle unless the skid slot is full and returns one result
// beat per input beat once the output is free. Registers live in a 16x32 RAM
// read in stage 1 (registered read) and written back in stage 2. A write in
// stage 2 is forwarded to the beat in stage 1 in the same cycle, and is also
// held in a register so that the beat whose RAM read was issued at the write
// edge (and so returned the old contents) picks it up too. Back-to-back
// dependent instructions therefore see each other's results. Flags sit in a
// 4-bit register updated in stage 2 and read there directly. A single-entry
// output register with a skid slot lets the input keep flowing while a result
// waits. Reset clears control state and the flags; the register file reads as
// zero until each entry is written, tracked by one valid bit per entry.
`default_nettype none
module thumb_data_processing_unit (
	input wire logic clk,
	input wire logic arst_n,
	tdpu_if.sink in_ch,
	tdpu_if.source out_ch
);
	import tdpu_pkg::*;

	// stage 1: read address decode
	in_beat_t b_s1, b_s2;
	logic v_s1, v_s2;
	logic [3:0] ra, rb, ra_s1, rb_s1;
	logic [15:0] ins;
	logic [RegN-1:0] vld_q;
	logic [3:0] flags_q;
	logic [31:0] ram_a, ram_b, a, b;
	logic we;
	logic [3:0] widx;
	logic [31:0] wval;
	out_beat_t res, obuf_q, skid_q;
	logic ovld_q, skid_vld_q, adv;

	assign ins = in_ch.data.instruction;
	always_comb begin
		ra = {1'b0, ins[5:3]};
		rb = {1'b0, ins[8:6]};
		if (ins[15:13] == 3'b001) begin
			ra = {1'b0, ins[10:8]};
		end else if (ins[15:10] == 6'b010000) begin
			ra = {1'b0, ins[2:0]};
			rb = {1'b0, ins[5:3]};
		end else if (ins[15:10] == 6'b010001) begin
			ra = {ins[7], ins[2:0]};
			rb = {ins[6], ins[5:3]};
		end
	end

	// stall when the skid slot is occupied
	assign adv = !skid_vld_q;
	assign in_ch.ready = adv;

	tdpu_ram #(.Width(DataW), .Depth(RegN)) u_rf (
		.clk(clk), .we(we), .waddr(widx), .wdata(wval),
		.raddr_a(adv ? ra : ra_s1), .raddr_b(adv ? rb : rb_s1),
		.rdata_a(ram_a), .rdata_b(ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1 <= in_ch.data;
			ra_s1 <= ra;
			rb_s1 <= rb;
			b_s2 <= b_s1;
		end
	end

	// stage 2 operand fetch: forward the write landing now, then the write from the
	// edge that issued this beat's RAM read
	logic fwd_we_q;
	logic [3:0] fwd_idx_q;
	logic [31:0] fwd_val_q;
	logic [31:0] a_s2, b_s2r;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_we_q <= 1'b0;
		end else begin
			fwd_we_q <= we;
		end
	end
	always_ff @(posedge clk) begin
		fwd_idx_q <= widx;
		fwd_val_q <= wval;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= (we && widx == ra_s1) ? wval :
				(fwd_we_q && fwd_idx_q == ra_s1) ? fwd_val_q :
				(vld_q[ra_s1] ? ram_a : '0);
			b_s2r <= (we && widx == rb_s1) ? wval :
				(fwd_we_q && fwd_idx_q == rb_s1) ? fwd_val_q :
				(vld_q[rb_s1] ? ram_b : '0);
		end
	end
	assign a = a_s2;
	assign b = b_s2r;

	// execute
	logic [15:0] ix;
	logic [32:0] sum;
	logic [31:0] add_x, add_y, r, sh_res, mul_p;
	logic add_ci, sh_c, use_add, use_sh, set_nz, keep_v;
	shift_t sh_kind;
	logic [31:0] sh_x;
	logic [7:0] sh_amt;
	logic [3:0] nf;
	logic hdl, wr;
	logic [3:0] didx;

	tdpu_shift u_sh (
		.kind(sh_kind), .x(sh_x), .amount(sh_amt), .cin(flags_q[1]),
		.res(sh_res), .cout(sh_c)
	);
	assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};
	assign mul_p = a * b;

	always_comb begin
		ix = b_s2.instruction;
		add_x = a; add_y = b; add_ci = 1'b0;
		sh_kind = shift_t'(ix[12:11]); sh_x = a; sh_amt = {3'd0, ix[10:6]};
		use_add = 1'b0; use_sh = 1'b0; set_nz = 1'b0; keep_v = 1'b1;
		r = '0; hdl = 1'b0; wr = 1'b0; didx = '0;
		nf = flags_q;
		case (op_t'(b_s2.op))
			OP_LDREG: begin
				wr = 1'b1; didx = b_s2.reg_index; r = b_s2.reg_value;
			end
			OP_LDFLAG: nf = b_s2.reg_value[31:28];
			OP_EXEC: begin
				if (ix[15:13] == 3'b000) begin
					hdl = 1'b1; set_nz = 1'b1; wr = 1'b1; didx = {1'b0, ix[2:0]};
					if (ix[12:11] != 2'd3) begin
						use_sh = 1'b1;
						if (ix[10:6] == 5'd0 && ix[12:11] != 2'd0) sh_amt = 8'd32;
					end else begin
						use_add = 1'b1;
						add_y = ix[10] ? {29'd0, ix[8:6]} : b;
						if (ix[9]) begin
							add_y = ~add_y; add_ci = 1'b1;
						end
					end
				end else if (ix[15:13] == 3'b001) begin
					hdl = 1'b1; set_nz = 1'b1; didx = {1'b0, ix[10:8]};
					wr = ix[12:11] != 2'd1;
					add_y = {24'd0, ix[7:0]};
					if (ix[12:11] == 2'd0) begin
						r = add_y;
					end else begin
						use_add = 1'b1;
						if (ix[12:11] != 2'd2) begin
							add_y = ~add_y; add_ci = 1'b1;
						end
					end
				end else if (ix[15:10] == 6'b010000) begin
					hdl = 1'b1; set_nz = 1'b1; didx = {1'b0, ix[2:0]};
					wr = 1'b1;
					sh_amt = b[7:0];
					case (alu_t'(ix[9:6]))
						ALU_AND, ALU_TST: r = a & b;
						ALU_EOR: r = a ^ b;
						ALU_LSL: begin use_sh = 1'b1; sh_kind = SH_LSL; end
						ALU_LSR: begin use_sh = 1'b1; sh_kind = SH_LSR; end
						ALU_ASR: begin use_sh = 1'b1; sh_kind = SH_ASR; end
						ALU_ROR: begin use_sh = 1'b1; sh_kind = SH_ROR; end
						ALU_ADC: begin use_add = 1'b1; add_ci = flags_q[1]; end
						ALU_SBC: begin use_add = 1'b1; add_y = ~b; add_ci = flags_q[1]; end
						ALU_NEG: begin
							use_add = 1'b1; add_x = '0; add_y = ~b; add_ci = 1'b1;
						end
						ALU_CMP: begin use_add = 1'b1; add_y = ~b; add_ci = 1'b1; end
						ALU_CMN: use_add = 1'b1;
						ALU_ORR: r = a | b;
						ALU_MUL: r = mul_p;
						ALU_BIC: r = a & ~b;
						default: r = ~b;
					endcase
					if (ix[9:6] == ALU_TST || ix[9:6] == ALU_CMP || ix[9:6] == ALU_CMN) begin
						wr = 1'b0;
					end
				end else if (ix[15:10] == 6'b010001 && ix[9:8] != 2'd3) begin
					hdl = 1'b1; didx = {ix[7], ix[2:0]};
					if (ix[9:8] == 2'd1) begin
						use_add = 1'b1; set_nz = 1'b1; add_y = ~b; add_ci = 1'b1;
					end else begin
						wr = 1'b1;
						r = ix[9:8] == 2'd0 ? a + b : b;
					end
				end
			end
			default: ;
		endcase
		if (use_add) begin
			r = sum[31:0];
			nf[1] = sum[32];
			nf[0] = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum[31]);
		end
		if (use_sh) begin
			r = sh_res;
			nf[1] = sh_c;
		end
		if (set_nz) begin
			nf[3] = r[31];
			nf[2] = r == '0;
		end
		if (!wr) begin
			didx = '0;
		end
		res.handled = hdl;
		res.dest_written = wr;
		res.dest_index = didx;
		res.dest_value = wr ? r : '0;
		{res.flag_n, res.flag_z, res.flag_c, res.flag_v} = nf;
		res.pc_written = b_s2.op == OP_EXEC && wr && didx == 4'd15;
	end

	assign we = v_s2 && adv && res.dest_written;
	assign widx = didx;
	assign wval = res.dest_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			vld_q <= '0;
		end else if (v_s2 && adv) begin
			flags_q <= nf;
			if (we) begin
				vld_q[widx] <= 1'b1;
			end
		end
	end

	// output register plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!ovld_q || out_ch.ready) begin
				ovld_q <= skid_vld_q || (v_s2 && adv);
				skid_vld_q <= 1'b0;
			end else if (v_s2 && adv) begin
				skid_vld_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (!ovld_q || out_ch.ready) begin
			obuf_q <= skid_vld_q ? skid_q : res;
		end else if (v_s2 && adv) begin
			skid_q <= res;
		end
	end
	assign out_ch.valid = ovld_q;
	assign out_ch.data = obuf_q;

	a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> ovld_q) else $error("skid full with empty output");
	a_no_advance_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !in_ch.ready) else $error("accept while skid full");
	a_pc_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		res.pc_written |-> res.dest_written) else $error("pc flag without write");
endmodule
`default_nettype wire

/* rtl/tdpu_ram.sv */
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module tdpu_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr_a,
	input wire logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0] rdata_a,
	output logic [Width-1:0] rdata_b
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

/* rtl/tdpu_shift.sv */
// ARM barrel shifter with carry out, amount 0..255.
// Depends on tdpu_pkg.
`default_nettype none
module tdpu_shift (
	input wire tdpu_pkg::shift_t kind,
	input wire logic [31:0] x,
	input wire logic [7:0] amount,
	input wire logic cin,
	output logic [31:0] res,
	output logic cout
);
	import tdpu_pkg::*;
	logic [63:0] ext;
	logic [4:0] k;
	logic big;
	always_comb begin
		k = amount[4:0];
		big = amount[7:5] != 3'd0;
		res = x;
		cout = cin;
		ext = '0;
		if (amount != 8'd0) begin
			case (kind)
				SH_LSL: begin
					ext = {32'd0, x} << k;
					if (!big) begin
						res = ext[31:0];
						cout = ext[32];
					end else begin
						res = '0;
						cout = (amount == 8'd32) ? x[0] : 1'b0;
					end
				end
				SH_LSR: begin
					ext = {x, 32'd0} >> k;
					if (!big) begin
						res = ext[63:32];
						cout = ext[31];
					end else begin
						res = '0;
						cout = (amount == 8'd32) ? x[31] : 1'b0;
					end
				end
				SH_ASR: begin
					ext = {x, 32'd0} >> k;
					if (!big) begin
						res = ext[63:32] | ~({32{1'b1}} >> k) & {32{x[31]}};
						cout = ext[31];
					end else begin
						res = {32{x[31]}};
						cout = x[31];
					end
				end
				default: begin
					ext = {x, x} >> k;
					res = ext[31:0];
					cout = ext[31];
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for thumb_data_processing_unit: Thumb ALU execute,
// register/flag loads, random idling on both channels.
// Depends on tdpu_pkg, tdpu_if and the RTL top level.
`default_nettype none
module testbench;
	import tdpu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned cycles = 0;
	bit quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tdpu_if #(.payload_t(in_beat_t)) in_ch (clk);
	tdpu_if #(.payload_t(out_beat_t)) out_ch (clk);

	thumb_data_processing_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// Scoreboard: shadow register file and NZCV, queue of predicted beats.
	class alu_scoreboard;
		logic [31:0] regs [16];
		logic [3:0] nzcv;
		out_beat_t pending[$];
		int errors;
		int checked;

		function void clear();
			foreach (regs[i]) regs[i] = '0;
			nzcv = '0;
			errors = 0;
			checked = 0;
		endfunction

		// 33-bit add, returns carry and overflow
		function logic [31:0] add33(logic [31:0] a, logic [31:0] b, logic cin,
				output logic c, output logic v);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
			c = s[32];
			v = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
			return s[31:0];
		endfunction

		function logic [31:0] shifter(shift_t kind, logic [31:0] x, int unsigned amt,
				logic cin, output logic cout);
			int unsigned k;
			cout = cin;
			if (amt == 0) return x;
			case (kind)
				SH_LSL: begin
					if (amt < 32) begin
						cout = x[32 - amt];
						return x << amt;
					end
					cout = (amt == 32) ? x[0] : 1'b0;
					return '0;
				end
				SH_LSR: begin
					if (amt < 32) begin
						cout = x[amt - 1];
						return x >> amt;
					end
					cout = (amt == 32) ? x[31] : 1'b0;
					return '0;
				end
				SH_ASR: begin
					if (amt < 32) begin
						cout = x[amt - 1];
						return $unsigned($signed(x) >>> amt);
					end
					cout = x[31];
					return {32{x[31]}};
				end
				default: begin
					k = amt % 32;
					x = (k == 0) ? x : ((x >> k) | (x << (32 - k)));
					cout = x[31];
					return x;
				end
			endcase
		endfunction

		function void note_input(in_beat_t b);
			out_beat_t o;
			logic [15:0] ins;
			logic [31:0] a, bb, r;
			logic c, v, cin;
			logic [3:0] rd, rs;
			int unsigned amt;
			alu_t alu;
			o = '0;
			ins = b.instruction;
			cin = nzcv[1];
			c = cin;
			v = nzcv[0];
			case (op_t'(b.op))
				OP_LDREG: begin
					regs[b.reg_index] = b.reg_value;
					o.dest_written = 1'b1;
					o.dest_index = b.reg_index;
					o.dest_value = b.reg_value;
				end
				OP_LDFLAG: nzcv = b.reg_value[31:28];
				OP_EXEC: begin
					if (ins[15:13] == 3'd0) begin
						o.handled = 1'b1;
						a = regs[ins[5:3]];
						if (ins[12:11] != 2'd3) begin
							amt = ins[10:6];
							if (amt == 0 && ins[12:11] != 2'd0) amt = 32;
							r = shifter(shift_t'(ins[12:11]), a, amt, cin, c);
							nzcv[1] = c;
						end else begin
							bb = ins[10] ? {29'd0, ins[8:6]} : regs[ins[8:6]];
							r = ins[9] ? add33(a, ~bb, 1'b1, c, v) : add33(a, bb, 1'b0, c, v);
							nzcv[1:0] = {c, v};
						end
						nzcv[3:2] = {r[31], r == 0};
						o.dest_written = 1'b1;
						o.dest_index = {1'b0, ins[2:0]};
						o.dest_value = r;
					end else if (ins[15:13] == 3'd1) begin
						o.handled = 1'b1;
						a = regs[ins[10:8]];
						if (ins[12:11] == 2'd0) r = {24'd0, ins[7:0]};
						else begin
							r = (ins[12:11] == 2'd2) ? add33(a, {24'd0, ins[7:0]}, 1'b0, c, v)
								: add33(a, ~{24'd0, ins[7:0]}, 1'b1, c, v);
							nzcv[1:0] = {c, v};
						end
						nzcv[3:2] = {r[31], r == 0};
						if (ins[12:11] != 2'd1) begin
							o.dest_written = 1'b1;
							o.dest_index = {1'b0, ins[10:8]};
							o.dest_value = r;
						end
					end else if (ins[15:10] == 6'h10) begin
						o.handled = 1'b1;
						alu = alu_t'(ins[9:6]);
						a = regs[ins[2:0]];
						bb = regs[ins[5:3]];
						amt = bb[7:0];
						case (alu)
							ALU_AND, ALU_TST: r = a & bb;
							ALU_EOR: r = a ^ bb;
							ALU_LSL: r = shifter(SH_LSL, a, amt, cin, c);
							ALU_LSR: r = shifter(SH_LSR, a, amt, cin, c);
							ALU_ASR: r = shifter(SH_ASR, a, amt, cin, c);
							ALU_ROR: r = shifter(SH_ROR, a, amt, cin, c);
							ALU_ADC: r = add33(a, bb, cin, c, v);
							ALU_SBC: r = add33(a, ~bb, cin, c, v);
							ALU_NEG: r = add33(32'd0, ~bb, 1'b1, c, v);
							ALU_CMP: r = add33(a, ~bb, 1'b1, c, v);
							ALU_CMN: r = add33(a, bb, 1'b0, c, v);
							ALU_ORR: r = a | bb;
							ALU_MUL: r = a * bb;
							ALU_BIC: r = a & ~bb;
							default: r = ~bb;
						endcase
						nzcv[1:0] = {c, v};
						nzcv[3:2] = {r[31], r == 0};
						if (alu != ALU_TST && alu != ALU_CMP && alu != ALU_CMN) begin
							o.dest_written = 1'b1;
							o.dest_index = {1'b0, ins[2:0]};
							o.dest_value = r;
						end
					end else if (ins[15:10] == 6'h11 && ins[9:8] != 2'd3) begin
						o.handled = 1'b1;
						rd = {ins[7], ins[2:0]};
						rs = {ins[6], ins[5:3]};
						if (ins[9:8] == 2'd1) begin
							r = add33(regs[rd], ~regs[rs], 1'b1, c, v);
							nzcv = {r[31], r == 0, c, v};
						end else begin
							o.dest_written = 1'b1;
							o.dest_index = rd;
							o.dest_value = (ins[9:8] == 2'd0) ? regs[rd] + regs[rs] : regs[rs];
						end
					end
					if (o.dest_written) regs[o.dest_index] = o.dest_value;
					o.pc_written = o.dest_written && o.dest_index == 4'd15;
				end
				default: ;
			endcase
			{o.flag_n, o.flag_z, o.flag_c, o.flag_v} = nzcv;
			pending.push_back(o);
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.handled !== e.handled) report("handled", e.handled, got.handled);
			if (got.dest_written !== e.dest_written)
				report("dest_written", e.dest_written, got.dest_written);
			if (got.dest_index !== e.dest_index) report("dest_index", e.dest_index, got.dest_index);
			if (got.dest_value !== e.dest_value) report("dest_value", e.dest_value, got.dest_value);
			if (got.flag_n !== e.flag_n) report("flag_n", e.flag_n, got.flag_n);
			if (got.flag_z !== e.flag_z) report("flag_z", e.flag_z, got.flag_z);
			if (got.flag_c !== e.flag_c) report("flag_c", e.flag_c, got.flag_c);
			if (got.flag_v !== e.flag_v) report("flag_v", e.flag_v, got.flag_v);
			if (got.pc_written !== e.pc_written) report("pc_written", e.pc_written, got.pc_written);
		endfunction

		function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
			$error("%s: expected %h, got %h", field, exp_v, act_v);
			errors++;
		endfunction
	endclass

	alu_scoreboard sb = new();

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	// Sample at the edge, before the NBA updates land.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
	end

	// Sink side: random stall bursts, none once quiet is set.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1'b1;
			n = $urandom_range(1, 20);
			repeat (n) @(posedge clk);
			if (!quiet) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// Present one beat and hold it until it is taken; maybe idle first.
	task automatic send_beat(in_beat_t b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_exec(logic [15:0] ins);
		in_beat_t b;
		b = '0;
		b.op = OP_EXEC;
		b.instruction = ins;
		b.reg_index = 4'($urandom);
		b.reg_value = $urandom;
		send_beat(b);
	endtask

	task automatic send_load(logic [3:0] idx, logic [31:0] val);
		in_beat_t b;
		b.op = OP_LDREG;
		b.instruction = 16'($urandom);
		b.reg_index = idx;
		b.reg_value = val;
		send_beat(b);
	endtask

	task automatic send_flags(logic [3:0] f);
		in_beat_t b;
		b.op = OP_LDFLAG;
		b.instruction = 16'($urandom);
		b.reg_index = 4'($urandom);
		b.reg_value = {f, 28'($urandom)};
		send_beat(b);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	// Mostly covered forms with random fields, some arbitrary halfwords.
	function automatic logic [15:0] rand_instr();
		logic [15:0] r;
		r = 16'($urandom);
		case ($urandom_range(0, 9))
			0, 1: r[15:13] = 3'b000;
			2, 3: r[15:13] = 3'b001;
			4, 5, 6: r[15:10] = 6'h10;
			7, 8: r[15:10] = 6'h11;
			default: ;
		endcase
		return r;
	endfunction

	task automatic random_item();
		in_beat_t b;
		case ($urandom_range(0, 19))
			0, 1, 2: send_load(4'($urandom), rand_word());
			3: send_flags(4'($urandom));
			4: begin
				b = {2'($urandom), 16'($urandom), 4'($urandom), 32'($urandom)};
				b.op = OP_NONE;
				send_beat(b);
			end
			default: send_exec(rand_instr());
		endcase
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		sb.clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every operation, long shifts, r15, odd ops.
		send_load(4'd0, 32'h8000_0001);
		send_load(4'd1, 32'd32);
		send_load(4'd2, 32'hFFFF_FFFF);
		send_load(4'd15, 32'h7FFF_FFFF);
		send_flags(4'hF);
		send_exec(16'h0001);              // LSL #0 keeps carry
		send_exec(16'h0803);              // LSR #32
		send_exec(16'h1004);              // ASR #32
		send_exec(16'h1C13);              // ADD r3,r2,#0
		send_exec(16'h1A53);              // SUB r3,r2,r1
		send_exec(16'h20FF);              // MOV r0,#255
		send_exec(16'h2A00);              // CMP r2,#0
		send_exec(16'h32FF);              // ADD r2,#255
		send_exec(16'h3F01);              // SUB r7,#1
		send_load(4'd0, 32'h8000_0001);
		for (int k = 0; k < 16; k++) send_exec({6'h10, 4'(k), 3'd1, 3'd0});
		send_exec(16'h41C8);              // ROR by r1 (amount 1: r1 = r0 from LSL #0)
		send_exec(16'h44FF);              // ADD pc,pc
		send_exec(16'h45FF);              // CMP pc,pc
		send_exec(16'h46F7);              // MOV pc,lr (hi-MOV)
		send_exec(16'h4778);              // BX: not handled
		send_exec(16'hFFFF);
		send_flags(4'h0);

		for (int i = 0; i < 1250; i++) begin
			if (i == 600) drain();        // stall until the pipe is empty
			if (i == 1100) quiet = 1'b1;
			random_item();
		end
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered loads, flag loads, all Thumb ALU forms and noise; %0d beats checked",
			sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (cycles == 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end
	end
endmodule
`default_nettype wire

/* thumb_data_processing_unit.f */
rtl/tdpu_pkg.sv
rtl/tdpu_if.sv
rtl/tdpu_ram.sv
rtl/tdpu_shift.sv
rtl/thumb_data_processing_unit.sv
dv/testbench.sv
